// ----- rtl/core/iq_ratio_packet_framer_unit_defines.svh -----
// assertion macros for the iq ratio packet framer
// used by the top level only, needs clk and rst_n in scope
`ifndef IQ_RATIO_PACKET_FRAMER_UNIT_DEFINES_SVH
`define IQ_RATIO_PACKET_FRAMER_UNIT_DEFINES_SVH

// consequent holds in the same cycle
`define IQRPF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iqrpf check failed");

// consequent holds in the cycle after the antecedent
`define IQRPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iqrpf check failed");

`endif

// ----- rtl/core/iqrpf_pkg.sv -----
// shared types, constants and single precision helpers for the framer
// no dependencies
`default_nettype none

package iqrpf_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int FRAME_LEN       = 14;
    localparam int IDX_W           = 4;
    localparam int ADDR_W          = 3;

    localparam logic [7:0]  SYNC0     = 8'h7F;
    localparam logic [7:0]  SYNC1     = 8'hFF;
    localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    localparam logic MODE_RAW   = 1'b0;
    localparam logic MODE_RATIO = 1'b1;
    localparam logic REG_SLOT_OUTPUT_MODE = 1'b0;

    typedef struct packed {
        logic [15:0] cnt;
        logic [31:0] ai;
        logic [31:0] aq;
        logic [31:0] bi;
        logic [31:0] bq;
        logic [15:0] ecg;
        logic        mode;
    } item_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } front_stat_t;

    typedef struct packed {
        logic            pop;
        logic            load;
        logic [IDX_W-1:0] idx;
    } back_stat_t;

    // int32 to single, round to nearest even
    function automatic logic [31:0] fp_from_int(input logic [31:0] u);
        logic        s;
        logic [31:0] mag;
        logic [31:0] norm;
        logic [4:0]  pos;
        logic        rnd;
        s   = u[31];
        mag = s ? (~u + 32'd1) : u;
        pos = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag[i])
            begin
                pos = 5'(i);
            end
        end
        norm = mag << (5'd31 - pos);
        rnd  = norm[7] & ((|norm[6:0]) | norm[8]);
        if (mag == 32'd0)
        begin
            return 32'd0;
        end
        return {s, 8'(8'd127 + {3'd0, pos}), norm[30:8]} + {31'd0, rnd};
    endfunction

    // single multiply, normal or zero operands, no overflow
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic [47:0] p;
        logic [9:0]  e;
        logic [23:0] m;
        logic        g;
        logic        st;
        s = a[31] ^ b[31];
        p = {1'b1, a[22:0]} * {1'b1, b[22:0]};
        e = {2'd0, a[30:23]} + {2'd0, b[30:23]} - 10'd127 + {9'd0, p[47]};
        if (p[47])
        begin
            m  = p[47:24];
            g  = p[23];
            st = |p[22:0];
        end
        else
        begin
            m  = p[46:23];
            g  = p[22];
            st = |p[21:0];
        end
        if (a[30:23] == 8'd0 || b[30:23] == 8'd0)
        begin
            return {s, 31'd0};
        end
        return {s, e[7:0], m[22:0]} + {31'd0, g & (st | m[0])};
    endfunction

    // single add, normal or zero operands
    function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] a;
        logic [31:0] b;
        logic [7:0]  d;
        logic [26:0] ma;
        logic [26:0] mb;
        logic [26:0] sh;
        logic [27:0] s;
        logic [26:0] n;
        logic [4:0]  pos;
        logic [7:0]  e;
        logic        rnd;
        if (x[30:0] >= y[30:0])
        begin
            a = x;
            b = y;
        end
        else
        begin
            a = y;
            b = x;
        end
        d  = a[30:23] - b[30:23];
        ma = {1'b1, a[22:0], 3'b000};
        mb = {1'b1, b[22:0], 3'b000};
        if (d >= 8'd27)
        begin
            sh = 27'd1;
        end
        else
        begin
            sh = (mb >> d) | {26'd0, |(mb & ((27'd1 << d) - 27'd1))};
        end
        if (a[31] == b[31])
        begin
            s = {1'b0, ma} + {1'b0, sh};
        end
        else
        begin
            s = {1'b0, ma} - {1'b0, sh};
        end
        pos = 5'd0;
        for (int i = 0; i < 27; i++)
        begin
            if (s[i])
            begin
                pos = 5'(i);
            end
        end
        if (s[27])
        begin
            n = {s[27:2], s[1] | s[0]};
            e = a[30:23] + 8'd1;
        end
        else
        begin
            n = s[26:0] << (5'd26 - pos);
            e = a[30:23] - 8'(5'd26 - pos);
        end
        rnd = n[2] & ((|n[1:0]) | n[3]);
        if (x[30:0] == 31'd0 && y[30:0] == 31'd0)
        begin
            return {x[31] & y[31], 31'd0};
        end
        if (x[30:0] == 31'd0)
        begin
            return y;
        end
        if (y[30:0] == 31'd0)
        begin
            return x;
        end
        if (s == 28'd0)
        begin
            return 32'd0;
        end
        return {a[31], e, n[25:3]} + {31'd0, rnd};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/iqrpf_front.sv -----
// front end: accepts beats, tags them with the mode and queues them
// depends on iqrpf_pkg
`default_nettype none

module iqrpf_front
    import iqrpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] packet_count,
    input  wire logic [31:0] a_in_phase,
    input  wire logic [31:0] a_quadrature,
    input  wire logic [31:0] b_in_phase,
    input  wire logic [31:0] b_quadrature,
    input  wire logic [31:0] ecg_sample,
    input  wire logic        mode,
    input  wire logic        pop,
    output item_t            head,
    output front_stat_t      stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             do_pop;

    assign in_stall       = (count_reg == CNT_FULL);
    assign push           = in_valid && !in_stall;
    assign do_pop         = pop && (count_reg != '0);
    assign head           = slot_reg[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.full      = in_stall;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{cnt: packet_count, ai: a_in_phase, aq: a_quadrature,
                                      bi: b_in_phase, bq: b_quadrature,
                                      ecg: ecg_sample[15:0], mode: mode};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/iqrpf_fdiv.sv -----
// iterative single precision divider, one quotient bit per cycle
// depends on iqrpf_pkg; operands normal, divisor nonzero
`default_nettype none

module iqrpf_fdiv
    import iqrpf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [31:0]      quo
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  step_reg;
    logic        sign_reg;
    logic [7:0]  exp_reg;
    logic [25:0] rem_reg;
    logic [23:0] dvs_reg;
    logic [24:0] q_reg;
    logic [23:0] mn;
    logic [23:0] md;
    logic        ge;
    logic [25:0] diff;

    assign mn   = {1'b1, num[22:0]};
    assign md   = {1'b1, den[22:0]};
    assign ge   = (rem_reg >= {2'b00, dvs_reg});
    assign diff = rem_reg - {2'b00, dvs_reg};
    assign done = done_reg;
    assign quo  = {sign_reg, exp_reg, q_reg[23:1]}
                + {31'd0, q_reg[0] & ((rem_reg != '0) | q_reg[1])};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sign_reg <= num[31] ^ den[31];
            dvs_reg  <= md;
            q_reg    <= '0;
            if (mn < md)
            begin
                rem_reg <= {1'b0, mn, 1'b0};
                exp_reg <= 8'({1'b0, num[30:23]} + 9'd126 - {1'b0, den[30:23]});
            end
            else
            begin
                rem_reg <= {2'b00, mn};
                exp_reg <= 8'({1'b0, num[30:23]} + 9'd127 - {1'b0, den[30:23]});
            end
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[23:0], ge};
            if (step_reg != 5'd24)
            begin
                rem_reg <= (ge ? diff : rem_reg) << 1;
            end
            else
            begin
                rem_reg <= ge ? diff : rem_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'd24)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/iqrpf_back.sv -----
// back end: ratio arithmetic sequencer and frame serializer
// depends on iqrpf_pkg and iqrpf_fdiv
`default_nettype none

module iqrpf_back
    import iqrpf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire item_t       head,
    input  wire front_stat_t fstat,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       frame_byte,
    output logic             last_byte,
    output back_stat_t       stat
);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_ARITH = 5'b00010,
        B_DIVRE = 5'b00100,
        B_DIVIM = 5'b01000,
        B_SEND  = 5'b10000
    } bstate_t;

    bstate_t          state_reg;
    item_t            item_reg;
    logic [31:0]      fai_reg, faq_reg, fbi_reg, fbq_reg;
    logic [31:0]      d1_reg, d2_reg, den_reg, p1_reg, p2_reg, nre_reg, nim_reg;
    logic [31:0]      re_reg, im_reg;
    logic [3:0]       k_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             div_go_reg;
    logic             out_valid_reg;
    logic [7:0]       frame_byte_reg;
    logic             last_reg;
    logic             load;
    logic             div_done;
    logic [31:0]      div_q;
    logic [31:0]      div_num;
    logic [31:0]      mul_a, mul_b, mul_y;
    logic [31:0]      add_a, add_b, add_y;
    logic [31:0]      div_fix;
    logic [7:0]       byte_sel;

    assign pop        = (state_reg == B_IDLE) && fstat.not_empty;
    assign load       = (state_reg == B_SEND) && (!out_valid_reg || !out_stall);
    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign last_byte  = last_reg;
    assign stat.pop   = pop;
    assign stat.load  = load;
    assign stat.idx   = idx_reg;
    assign div_num    = (state_reg == B_DIVIM) ? nim_reg : nre_reg;

    iqrpf_fdiv u_fdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go_reg),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    always_comb
    begin
        mul_a = fbi_reg;
        mul_b = fbi_reg;
        add_a = d1_reg;
        add_b = d2_reg;
        case (k_reg)
            4'd1:
            begin
                mul_a = fbq_reg;
                mul_b = fbq_reg;
            end
            4'd2:
            begin
                mul_a = fai_reg;
                mul_b = fbi_reg;
            end
            4'd3:
            begin
                mul_a = faq_reg;
                mul_b = fbq_reg;
            end
            4'd5:
            begin
                add_a = p1_reg;
                add_b = p2_reg;
            end
            4'd6:
            begin
                mul_a = {~fai_reg[31], fai_reg[30:0]};
                mul_b = fbq_reg;
            end
            4'd7:
            begin
                mul_a = faq_reg;
                mul_b = fbi_reg;
            end
            4'd8:
            begin
                add_a = p1_reg;
                add_b = p2_reg;
            end
            default:
            begin
                mul_a = fbi_reg;
                mul_b = fbi_reg;
            end
        endcase
        mul_y = fp_mul(mul_a, mul_b);
        add_y = fp_add(add_a, add_b);
    end

    always_comb
    begin
        if (den_reg[30:23] == 8'd0)
        begin
            div_fix = QNAN_BITS;
        end
        else if (div_num[30:0] == 31'd0)
        begin
            div_fix = {div_num[31], 31'd0};
        end
        else
        begin
            div_fix = div_q;
        end
    end

    always_comb
    begin
        case (idx_reg)
            4'd0:  byte_sel = SYNC0;
            4'd1:  byte_sel = SYNC1;
            4'd2:  byte_sel = item_reg.cnt[7:0];
            4'd3:  byte_sel = item_reg.cnt[15:8];
            4'd4:  byte_sel = (item_reg.mode == MODE_RATIO) ? re_reg[7:0]   : item_reg.ai[23:16];
            4'd5:  byte_sel = (item_reg.mode == MODE_RATIO) ? re_reg[15:8]  : item_reg.ai[31:24];
            4'd6:  byte_sel = (item_reg.mode == MODE_RATIO) ? re_reg[23:16] : item_reg.aq[23:16];
            4'd7:  byte_sel = (item_reg.mode == MODE_RATIO) ? re_reg[31:24] : item_reg.aq[31:24];
            4'd8:  byte_sel = (item_reg.mode == MODE_RATIO) ? im_reg[7:0]   : item_reg.bi[23:16];
            4'd9:  byte_sel = (item_reg.mode == MODE_RATIO) ? im_reg[15:8]  : item_reg.bi[31:24];
            4'd10: byte_sel = (item_reg.mode == MODE_RATIO) ? im_reg[23:16] : item_reg.bq[23:16];
            4'd11: byte_sel = (item_reg.mode == MODE_RATIO) ? im_reg[31:24] : item_reg.bq[31:24];
            4'd12: byte_sel = item_reg.ecg[7:0];
            4'd13: byte_sel = item_reg.ecg[15:8];
            default: byte_sel = SYNC0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
            fai_reg  <= fp_from_int(head.ai);
            faq_reg  <= fp_from_int(head.aq);
            fbi_reg  <= fp_from_int(head.bi);
            fbq_reg  <= fp_from_int(head.bq);
        end
        if (state_reg == B_ARITH)
        begin
            case (k_reg)
                4'd0:    d1_reg  <= mul_y;
                4'd1:    d2_reg  <= mul_y;
                4'd2:    p1_reg  <= mul_y;
                4'd3:    p2_reg  <= mul_y;
                4'd4:    den_reg <= add_y;
                4'd5:    nre_reg <= add_y;
                4'd6:    p1_reg  <= mul_y;
                4'd7:    p2_reg  <= mul_y;
                4'd8:    nim_reg <= add_y;
                default: d1_reg  <= d1_reg;
            endcase
        end
        if (state_reg == B_DIVRE && div_done)
        begin
            re_reg <= div_fix;
        end
        if (state_reg == B_DIVIM && div_done)
        begin
            im_reg <= div_fix;
        end
        if (load)
        begin
            frame_byte_reg <= byte_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            k_reg         <= '0;
            idx_reg       <= '0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            if (load)
            begin
                out_valid_reg <= 1'b1;
                last_reg      <= (idx_reg == LAST_IDX);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        k_reg   <= '0;
                        idx_reg <= '0;
                        state_reg <= (head.mode == MODE_RATIO) ? B_ARITH : B_SEND;
                    end
                end
                B_ARITH:
                begin
                    k_reg <= k_reg + 4'd1;
                    if (k_reg == 4'd8)
                    begin
                        div_go_reg <= 1'b1;
                        state_reg  <= B_DIVRE;
                    end
                end
                B_DIVRE:
                begin
                    if (div_done)
                    begin
                        div_go_reg <= 1'b1;
                        state_reg  <= B_DIVIM;
                    end
                end
                B_DIVIM:
                begin
                    if (div_done)
                    begin
                        state_reg <= B_SEND;
                    end
                end
                B_SEND:
                begin
                    if (load)
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                        if (idx_reg == LAST_IDX)
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/iq_ratio_packet_framer_unit.sv -----
// top level of the iq ratio packet framer: config register, front queue, back end
// depends on iqrpf_pkg, iqrpf_front, iqrpf_back and the defines header
//
// usage
//   input channel: in_valid/in_stall with the packet count, four signed i/q
//   accumulators and the ecg accumulator; a beat is taken when in_valid is
//   high and in_stall low. a small queue takes new beats while a frame is sent
//   output channel: out_valid/out_stall, one frame byte per beat, fourteen
//   beats per packet, last_byte on the fourteenth
//   raw mode: the back end sends the bytes of each beat, one byte per cycle
//   while out_stall is low. ratio mode: float multiplies and adds, then two
//   divides on the shared iterative divider, then 14 bytes
//   output_mode lives at byte address 0 of the apb port, write it while idle
//   reset empties the queue, drops any frame in flight and sets raw mode
//   a stalled output byte holds; the back end waits and the queue fills,
//   after which in_stall rises
`default_nettype none

`include "iq_ratio_packet_framer_unit_defines.svh"

module iq_ratio_packet_framer_unit
    import iqrpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [15:0]        packet_count,
    input  wire logic signed [31:0] a_in_phase,
    input  wire logic signed [31:0] a_quadrature,
    input  wire logic signed [31:0] b_in_phase,
    input  wire logic signed [31:0] b_quadrature,
    input  wire logic [31:0]        ecg_sample,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              frame_byte,
    output logic                    last_byte,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic        mode_reg;
    item_t       head;
    front_stat_t fstat;
    back_stat_t  bstat;
    logic        pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLOT_OUTPUT_MODE) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RAW;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_SLOT_OUTPUT_MODE)
        begin
            mode_reg <= pwdata[0];
        end
    end

    iqrpf_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .packet_count (packet_count),
        .a_in_phase   (a_in_phase),
        .a_quadrature (a_quadrature),
        .b_in_phase   (b_in_phase),
        .b_quadrature (b_quadrature),
        .ecg_sample   (ecg_sample),
        .mode         (mode_reg),
        .pop          (pop),
        .head         (head),
        .stat         (fstat)
    );

    iqrpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .fstat      (fstat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .stat       (bstat)
    );

    `IQRPF_ASSERT_NOW(a_pop_nonempty, bstat.pop, fstat.not_empty)
    `IQRPF_ASSERT_NEXT(a_first_sync, bstat.load && bstat.idx == '0, frame_byte == SYNC0 && !last_byte)
    `IQRPF_ASSERT_NEXT(a_last_flag, bstat.load && bstat.idx == LAST_IDX, last_byte && out_valid)

endmodule

`default_nettype wire

// ----- tb/iq_ratio_packet_framer_unit_tb.sv -----
// self-checking testbench for the iq ratio packet framer, raw and ratio modes
// needs iqrpf_pkg and the iq_ratio_packet_framer_unit rtl
`default_nettype none

module testbench;
    import iqrpf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] frame_byte;
        logic       last_byte;
    } frame_beat_t;

    class frame_scoreboard;
        frame_beat_t expected_beats[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // round a double to single precision, nearest even
        function logic [31:0] to_single(real r);
            logic [63:0] b;
            logic [52:0] mant;
            logic [7:0]  exp8;
            logic        rnd;
            b = $realtobits(r);
            if (b[62:52] == 11'd0)
            begin
                return {b[63], 31'd0};
            end
            mant = {1'b1, b[51:0]};
            exp8 = 8'(b[62:52] - 11'd1023 + 11'd127);
            rnd  = mant[28] & ((|mant[27:0]) | mant[29]);
            return {b[63], exp8, mant[51:29]} + {31'd0, rnd};
        endfunction

        function real from_single(logic [31:0] f);
            if (f[30:23] == 8'd0)
            begin
                return $bitstoreal({f[31], 63'd0});
            end
            return $bitstoreal({f[31], 11'(f[30:23] - 8'd127 + 11'd1023), f[22:0], 29'd0});
        endfunction

        function real rs(real r);
            return from_single(to_single(r));
        endfunction

        function void note_packet(logic mode, logic [15:0] cnt, logic [31:0] ai,
                                  logic [31:0] aq, logic [31:0] bi, logic [31:0] bq,
                                  logic [31:0] ecg);
            logic [7:0]  frame[14];
            logic [31:0] re_bits;
            logic [31:0] im_bits;
            real         fai;
            real         faq;
            real         fbi;
            real         fbq;
            real         den;
            real         num;
            frame_beat_t beat;
            frame[0] = SYNC0;
            frame[1] = SYNC1;
            frame[2] = cnt[7:0];
            frame[3] = cnt[15:8];
            if (mode == MODE_RAW)
            begin
                frame[4]  = ai[23:16];
                frame[5]  = ai[31:24];
                frame[6]  = aq[23:16];
                frame[7]  = aq[31:24];
                frame[8]  = bi[23:16];
                frame[9]  = bi[31:24];
                frame[10] = bq[23:16];
                frame[11] = bq[31:24];
            end
            else
            begin
                fai = rs($itor($signed(ai)));
                faq = rs($itor($signed(aq)));
                fbi = rs($itor($signed(bi)));
                fbq = rs($itor($signed(bq)));
                if (bi == 32'd0 && bq == 32'd0)
                begin
                    re_bits = QNAN_BITS;
                    im_bits = QNAN_BITS;
                end
                else
                begin
                    den     = rs(rs(fbi * fbi) + rs(fbq * fbq));
                    num     = rs(rs(fai * fbi) + rs(faq * fbq));
                    re_bits = to_single(num / den);
                    num     = rs(rs((-fai) * fbq) + rs(faq * fbi));
                    im_bits = to_single(num / den);
                end
                for (int i = 0; i < 4; i++)
                begin
                    frame[4 + i] = re_bits[8 * i +: 8];
                    frame[8 + i] = im_bits[8 * i +: 8];
                end
            end
            frame[12] = ecg[7:0];
            frame[13] = ecg[15:8];
            for (int i = 0; i < 14; i++)
            begin
                beat.frame_byte = frame[i];
                beat.last_byte  = (i == 13);
                expected_beats.push_back(beat);
            end
        endfunction

        function void check_beat(logic [7:0] fb, logic lb);
            frame_beat_t exp_beat;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected output beat frame_byte=%h last_byte=%b", fb, lb);
                errors++;
                return;
            end
            exp_beat = expected_beats.pop_front();
            if (fb !== exp_beat.frame_byte)
            begin
                $error("frame_byte expected %h actual %h", exp_beat.frame_byte, fb);
                errors++;
            end
            if (lb !== exp_beat.last_byte)
            begin
                $error("last_byte expected %b actual %b", exp_beat.last_byte, lb);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        packet_count;
    logic signed [31:0] a_in_phase;
    logic signed [31:0] a_quadrature;
    logic signed [31:0] b_in_phase;
    logic signed [31:0] b_quadrature;
    logic [31:0]        ecg_sample;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         frame_byte;
    logic               last_byte;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    frame_scoreboard sb;
    logic            cur_mode;
    int              send_idle_pct;
    int              recv_idle_pct;

    iq_ratio_packet_framer_unit dut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_beat(frame_byte, last_byte);
        end
    end

    task automatic write_mode(logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * REG_SLOT_OUTPUT_MODE);
        pwdata  <= {$urandom_range(1) ? 31'h7FFFFFFE : 31'd0, mode};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_mode = mode;
    endtask

    task automatic drain();
        while (sb.expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
    endtask

    task automatic send_packet(logic [15:0] cnt, logic [31:0] ai, logic [31:0] aq,
                               logic [31:0] bi, logic [31:0] bq, logic [31:0] ecg);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        packet_count <= cnt;
        a_in_phase   <= ai;
        a_quadrature <= aq;
        b_in_phase   <= bi;
        b_quadrature <= bq;
        ecg_sample   <= ecg;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_packet(cur_mode, cnt, ai, aq, bi, bq, ecg);
    endtask

    function automatic logic [31:0] rand_acc();
        case ($urandom_range(5))
            0: return 32'($urandom_range(200)) - 32'd100;
            1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            2: return 32'd0;
            3: return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_packets(int n);
        logic [31:0] bi;
        logic [31:0] bq;
        for (int i = 0; i < n; i++)
        begin
            bi = rand_acc();
            bq = rand_acc();
            if ($urandom_range(19) == 0)
            begin
                bi = 32'd0;
                bq = 32'd0;
            end
            send_packet(16'($urandom), rand_acc(), rand_acc(), bi, bq, $urandom);
        end
    endtask

    task automatic directed_packets();
        send_packet(16'h0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_packet(16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    32'hFFFFFFFF);
        send_packet(16'h8001, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h00010000);
        send_packet(16'h1234, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                    32'h0000A55A);
        send_packet(16'h00FF, 32'd5, 32'hFFFFFFFD, 32'd0, 32'd0, 32'h12345678);
        send_packet(16'hFF00, 32'd1, 32'd1, 32'd0, 32'd3, 32'h0000FFFF);
        send_packet(16'h0102, 32'h01000001, 32'h01000003, 32'd7, 32'd0, 32'hDEADBEEF);
        send_packet(16'h7F7F, 32'hFEFFFFFF, 32'h00FFFFFF, 32'h01000001, 32'hFF000001,
                    32'h00000001);
        send_packet(16'hA5A5, 32'd1, 32'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        send_packet(16'h5A5A, 32'h12345678, 32'h9ABCDEF0, 32'h0FEDCBA9, 32'h87654321,
                    32'h0000007F);
        send_packet(16'h0001, 32'd0, 32'd0, 32'hFFFFFFFF, 32'd1, 32'h0000FF7F);
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        packet_count  = '0;
        a_in_phase    = '0;
        a_quadrature  = '0;
        b_in_phase    = '0;
        b_quadrature  = '0;
        ecg_sample    = '0;
        out_stall     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cur_mode      = MODE_RAW;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        directed_packets();
        in_valid <= 1'b0;
        drain();
        write_mode(MODE_RATIO);
        directed_packets();
        in_valid <= 1'b0;
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 16 : 0;
            write_mode(MODE_RAW);
            random_packets(60);
            in_valid <= 1'b0;
            drain();
            write_mode(MODE_RATIO);
            random_packets(66);
            in_valid <= 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.expected_beats.size() == 0)
        begin
            $display("iq_ratio_packet_framer_unit verification clean");
        end
        else
        begin
            $display("iq_ratio_packet_framer_unit verification failed");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("iq_ratio_packet_framer_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
